// ----- src/ntc_pkg.sv -----
package ntc_pkg;

  localparam int ADC_BITS = 12;
  localparam int DIV_W = 16;
  localparam int NUM_W = ADC_BITS + DIV_W;
  localparam int TABLE_POINTS = 17;
  localparam int IDX_W = $clog2(TABLE_POINTS);
  localparam int OHM_W = 18;
  localparam int SPAN_W = 17;
  localparam int FRAC_W = 12;
  localparam int TEMP_W = 17;

  localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;

  localparam logic [OHM_W-1:0] NTC_OHMS [TABLE_POINTS] = '{
    18'd190953, 18'd112440, 18'd68260, 18'd42636, 18'd27348, 18'd17979,
    18'd12094, 18'd8311, 18'd5825, 18'd4158, 18'd3020, 18'd2228,
    18'd1668, 18'd1267, 18'd974, 18'd758, 18'd597
  };

  localparam logic signed [TEMP_W-1:0] TEMP_COLD = -17'sd10240;
  localparam logic signed [TEMP_W-1:0] TEMP_HOT = 17'sd30720;
  localparam logic signed [TEMP_W-1:0] TEMP_FAULT = 17'sd64000;
  localparam logic [TEMP_W-1:0] SEG_STEP_Q8 = 17'd2560;
  localparam logic [TEMP_W-1:0] SEG_BASE_Q8 = 17'd12800;

  localparam logic [11:0] RST_ADC_MIN = 12'd300;
  localparam logic [11:0] RST_ADC_MAX = 12'd4000;
  localparam logic [15:0] RST_DIVIDER = 16'd5100;

  typedef enum logic [1:0] {
    CFG_ADC_MIN = 2'd0,
    CFG_ADC_MAX = 2'd1,
    CFG_DIVIDER = 2'd2
  } ntc_cfg_t;

  typedef struct packed {
    logic             fault;
    logic             cold;
    logic             hot;
    logic [IDX_W-1:0] idx;
  } ntc_side_t;

endpackage

// ----- src/ntc_adc_to_temperature_unit.sv -----
// throughput: one sample per cycle; the whole pipeline advances together
// and holds while a finished result waits on out_ready
// two restoring dividers, one quotient bit per stage, set the depth
// rst clears all valid bits and loads the limits 300 / 4000 and divider 5100
module ntc_adc_to_temperature_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ntc_pkg::ADC_BITS-1:0]        adc_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ntc_pkg::TEMP_W-1:0]   temperature_q8,
  output logic                                sensor_fault,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data
);
  import ntc_pkg::*;

  logic [11:0] adc_min_valid;
  logic [11:0] adc_max_valid;
  logic [15:0] divider_ohms;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_min_valid <= RST_ADC_MIN;
      adc_max_valid <= RST_ADC_MAX;
      divider_ohms <= RST_DIVIDER;
    end else if (cfg_we) begin
      case (ntc_cfg_t'(cfg_index))
        CFG_ADC_MIN: adc_min_valid <= cfg_data[11:0];
        CFG_ADC_MAX: adc_max_valid <= cfg_data[11:0];
        CFG_DIVIDER: divider_ohms <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = ~out_valid | out_ready;
  assign in_ready = en;

  // input stage
  logic                v0;
  logic [NUM_W-1:0]    num0;
  logic [ADC_BITS-1:0] den0;
  logic [1:0]          sb0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      num0 <= NUM_W'(divider_ohms) * NUM_W'(adc_sample);
      den0 <= FULL_SCALE - adc_sample;
      sb0 <= {(adc_sample < adc_min_valid) | (adc_sample > adc_max_valid),
              adc_sample == FULL_SCALE};
    end
  end

  logic             v1;
  logic [NUM_W-1:0] r1;
  logic [1:0]       sb1;

  ntc_div_pipe #(
    .NUM_W(NUM_W), .DEN_W(ADC_BITS), .Q_W(NUM_W), .SB_W(2)
  ) u_div_r (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .num(num0), .den(den0),
    .side_in(sb0), .out_valid(v1), .quo(r1), .side_out(sb1)
  );

  logic              v2;
  logic [NUM_W-1:0]  num2;
  logic [SPAN_W-1:0] den2;
  ntc_side_t         side2;

  ntc_seg u_seg (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .r(r1),
    .fault_in(sb1[1]), .full_in(sb1[0]), .out_valid(v2), .num2(num2),
    .den2(den2), .side(side2)
  );

  logic                  v3;
  logic [FRAC_W-1:0]     frac3;
  logic [$bits(ntc_side_t)-1:0] sb3;
  ntc_side_t             side3;

  ntc_div_pipe #(
    .NUM_W(NUM_W), .DEN_W(SPAN_W), .Q_W(FRAC_W), .SB_W($bits(ntc_side_t))
  ) u_div_frac (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .num(num2), .den(den2),
    .side_in(side2), .out_valid(v3), .quo(frac3), .side_out(sb3)
  );

  assign side3 = ntc_side_t'(sb3);

  logic signed [TEMP_W-1:0] temp_next;
  logic [TEMP_W-1:0]        base;

  always_comb begin
    base = TEMP_W'(TEMP_W'(side3.idx) * SEG_STEP_Q8) - SEG_BASE_Q8;
    if (side3.fault) begin
      temp_next = TEMP_FAULT;
    end else if (side3.cold) begin
      temp_next = TEMP_COLD;
    end else if (side3.hot) begin
      temp_next = TEMP_HOT;
    end else begin
      temp_next = $signed(base + TEMP_W'(frac3));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      temperature_q8 <= temp_next;
      sensor_fault <= side3.fault;
    end
  end

  a_fault_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && sensor_fault |-> temperature_q8 == TEMP_FAULT)
    else $error("fault result without fault temperature");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sensor_fault |-> temperature_q8 >= TEMP_COLD && temperature_q8 <= TEMP_HOT)
    else $error("temperature outside table range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature_q8))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("valid after reset");

endmodule

// ----- src/ntc_div_pipe.sv -----
module ntc_div_pipe #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12,
  parameter int Q_W = 28,
  parameter int SB_W = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  side_in,
  output logic             out_valid,
  output logic [Q_W-1:0]   quo,
  output logic [SB_W-1:0]  side_out
);

  logic [DEN_W-1:0] rem   [Q_W+1];
  logic [Q_W-1:0]   low   [Q_W+1];
  logic [Q_W-1:0]   q     [Q_W+1];
  logic [DEN_W-1:0] den_s [Q_W+1];
  logic [SB_W-1:0]  sb    [Q_W+1];
  logic             v     [Q_W+1];

  assign rem[0] = DEN_W'(num >> Q_W);
  assign low[0] = num[Q_W-1:0];
  assign q[0] = '0;
  assign den_s[0] = den;
  assign sb[0] = side_in;
  assign v[0] = in_valid;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] sub;
    logic           ge;

    assign trial = {rem[k], low[k][Q_W-1]};
    assign sub = trial - {1'b0, den_s[k]};
    assign ge = trial >= {1'b0, den_s[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
      if (en) begin
        rem[k+1] <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
        low[k+1] <= low[k] << 1;
        q[k+1] <= {q[k][Q_W-2:0], ge};
        den_s[k+1] <= den_s[k];
        sb[k+1] <= sb[k];
      end
    end
  end

  assign out_valid = v[Q_W];
  assign quo = q[Q_W];
  assign side_out = sb[Q_W];

endmodule

// ----- src/ntc_seg.sv -----
module ntc_seg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ntc_pkg::NUM_W-1:0] r,
  input  logic                      fault_in,
  input  logic                      full_in,
  output logic                      out_valid,
  output logic [ntc_pkg::NUM_W-1:0] num2,
  output logic [ntc_pkg::SPAN_W-1:0] den2,
  output ntc_pkg::ntc_side_t        side
);
  import ntc_pkg::*;

  // compare stage
  logic [TABLE_POINTS-1:0] ge_n;
  logic [TABLE_POINTS-1:0] ge;
  logic [SPAN_W-1:0]       r_low;
  logic                    fault1;
  logic                    full1;
  logic                    v1;

  always_comb begin
    for (int j = 0; j < TABLE_POINTS; j++) begin
      ge_n[j] = r >= NUM_W'(NTC_OHMS[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ge <= ge_n;
      r_low <= r[SPAN_W-1:0];
      fault1 <= fault_in;
      full1 <= full_in;
    end
  end

  // segment select stage
  logic [IDX_W-1:0]  idx_n;
  logic [OHM_W-1:0]  hi;
  logic [OHM_W-1:0]  lo;
  logic [SPAN_W-1:0] diff;
  ntc_side_t         side_n;

  always_comb begin
    idx_n = IDX_W'(TABLE_POINTS - 1);
    for (int j = TABLE_POINTS - 1; j >= 1; j--) begin
      if (ge[j]) begin
        idx_n = IDX_W'(j);
      end
    end
    hi = NTC_OHMS[idx_n - IDX_W'(1)];
    lo = NTC_OHMS[idx_n];
    diff = hi[SPAN_W-1:0] - r_low;
    side_n.fault = fault1;
    side_n.cold = full1 | ge[0];
    side_n.hot = ~ge[TABLE_POINTS-1];
    side_n.idx = idx_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      num2 <= (NUM_W'(diff) << 11) + (NUM_W'(diff) << 9);
      den2 <= SPAN_W'(hi - lo);
      side <= side_n;
    end
  end

endmodule
